@@ rtl/core/blcr_pkg.sv @@
// shared constants and types for the basic line chain relinker
`timescale 1ns / 1ps

package blcr_pkg;

    localparam int MAX_PROGRAM_BYTES = 65536;
    localparam int POS_W             = 17;
    localparam int ADDR_W            = 16;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 16;
    localparam logic [7:0] BODY_LIMIT = 8'd255;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RELINK_ENABLE = 8'd0,
        CFG_RELINK_BASE   = 8'd1,
        CFG_CHECK_ENABLE  = 8'd2,
        CFG_CHECK_BASE    = 8'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_RUN   = 2'd0,
        STATUS_DONE  = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        PH_PTR_LO = 7'b0000001,
        PH_PTR_HI = 7'b0000010,
        PH_NUM_LO = 7'b0000100,
        PH_NUM_HI = 7'b0001000,
        PH_BODY   = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } phase_t;

endpackage

@@ rtl/core/blcr_in_if.sv @@
// input byte channel
`timescale 1ns / 1ps

interface blcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;
    logic       last;

    modport source (output valid, output data_byte, output first, output last, input ready);
    modport sink (input valid, input data_byte, input first, input last, output ready);
endinterface

@@ rtl/core/blcr_out_if.sv @@
// result channel
`timescale 1ns / 1ps

interface blcr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        patch_valid;
    logic [15:0] patch_offset;
    logic [15:0] patch_value;
    logic [15:0] relink_count;
    logic [16:0] program_size;

    modport source (output valid, output status, output patch_valid, output patch_offset,
                    output patch_value, output relink_count, output program_size,
                    input ready);
    modport sink (input valid, input status, input patch_valid, input patch_offset,
                  input patch_value, input relink_count, input program_size,
                  output ready);
endinterface

@@ rtl/core/blcr_cfg_if.sv @@
// configuration write channel
`timescale 1ns / 1ps

interface blcr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/basic_line_chain_relinker.sv @@
// line chain relinker and checker for a tokenized basic program
// the result beat of an accepted byte is registered and is offered in the next cycle
// throughput: one byte per cycle while results are taken, set by the single state update register stage
// a waiting result holds the next byte back unless the result leaves in the same cycle
// reset: asynchronous active low, clears configuration, chain state and result valid to the start of a program
`timescale 1ns / 1ps

module basic_line_chain_relinker
    import blcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    blcr_in_if.sink    in_ch,
    blcr_out_if.source out_ch,
    blcr_cfg_if.sink   cfg
);

    logic                  relink_enable_reg;
    logic [ADDR_W-1:0]     relink_base_reg;
    logic                  check_enable_reg;
    logic [ADDR_W-1:0]     check_base_reg;

    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      position_reg, position_next;
    logic [ADDR_W-1:0]     line_start_reg, line_start_next;
    logic [ADDR_W-1:0]     next_pointer_reg, next_pointer_next;
    logic [7:0]            body_length_reg, body_length_next;
    logic [POS_W-1:0]      target_reg, target_next;
    logic [POS_W-1:0]      source_reg, source_next;
    logic [15:0]           patch_total_reg, patch_total_next;

    logic                  out_valid_reg;
    status_t               status_reg, status_next;
    logic                  patch_valid_reg, patch_valid_next;
    logic [15:0]           patch_offset_reg, patch_offset_next;
    logic [15:0]           patch_value_reg, patch_value_next;
    logic [POS_W-1:0]      program_size_reg, program_size_next;

    logic                  in_fire;
    logic                  out_fire;

    phase_t                ph;
    logic [POS_W-1:0]      pos;
    logic [ADDR_W-1:0]     ls;
    logic [ADDR_W-1:0]     np;
    logic [7:0]            bl;
    logic [POS_W-1:0]      rt;
    logic [POS_W-1:0]      rs;
    logic [15:0]           pt;
    logic [POS_W-1:0]      len;
    logic [ADDR_W-1:0]     np_full;
    logic                  patch;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relink_enable_reg <= 1'b0;
            relink_base_reg   <= '0;
            check_enable_reg  <= 1'b0;
            check_base_reg    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_RELINK_ENABLE: relink_enable_reg <= cfg.data[0];
                CFG_RELINK_BASE:   relink_base_reg   <= cfg.data;
                CFG_CHECK_ENABLE:  check_enable_reg  <= cfg.data[0];
                CFG_CHECK_BASE:    check_base_reg    <= cfg.data;
                default:           ;
            endcase
        end
    end

    // effective state after an optional restart
    always_comb
    begin
        if (in_ch.first)
        begin
            ph  = PH_PTR_LO;
            pos = '0;
            ls  = '0;
            np  = '0;
            bl  = '0;
            rt  = {1'b0, relink_base_reg};
            rs  = {1'b0, check_base_reg};
            pt  = '0;
        end
        else
        begin
            ph  = phase_reg;
            pos = position_reg;
            ls  = line_start_reg;
            np  = next_pointer_reg;
            bl  = body_length_reg;
            rt  = target_reg;
            rs  = source_reg;
            pt  = patch_total_reg;
        end
    end

    assign len     = (pos + POS_W'(1)) - {1'b0, ls};
    assign np_full = {in_ch.data_byte, np[7:0]};

    always_comb
    begin
        phase_next        = ph;
        position_next     = pos;
        line_start_next   = ls;
        next_pointer_next = np;
        body_length_next  = bl;
        target_next       = rt;
        source_next       = rs;
        patch_total_next  = pt;
        patch             = 1'b0;
        patch_offset_next = '0;
        patch_value_next  = '0;

        if (ph != PH_DONE && ph != PH_ERROR)
        begin
            if (pos >= POS_W'(MAX_PROGRAM_BYTES))
            begin
                phase_next = PH_ERROR;
            end
            else
            begin
                unique case (ph)
                    PH_PTR_LO:
                    begin
                        line_start_next   = pos[ADDR_W-1:0];
                        next_pointer_next = {8'd0, in_ch.data_byte};
                        phase_next        = PH_PTR_HI;
                    end
                    PH_PTR_HI:
                    begin
                        next_pointer_next = np_full;
                        phase_next = (np_full == '0) ? PH_DONE : PH_NUM_LO;
                    end
                    PH_NUM_LO:
                    begin
                        phase_next = PH_NUM_HI;
                    end
                    PH_NUM_HI:
                    begin
                        body_length_next = '0;
                        phase_next       = PH_BODY;
                    end
                    default:
                    begin
                        if (in_ch.data_byte == 8'd0)
                        begin
                            phase_next = PH_PTR_LO;
                            if (check_enable_reg)
                            begin
                                source_next = rs + len;
                                if (source_next != {1'b0, np})
                                    phase_next = PH_ERROR;
                            end
                            if (phase_next != PH_ERROR && relink_enable_reg)
                            begin
                                target_next = rt + len;
                                if (target_next != {1'b0, np})
                                begin
                                    patch             = 1'b1;
                                    patch_offset_next = ls;
                                    patch_value_next  = target_next[ADDR_W-1:0];
                                end
                            end
                        end
                        else
                        begin
                            body_length_next = bl + 8'd1;
                            if (body_length_next >= BODY_LIMIT)
                                phase_next = PH_ERROR;
                        end
                    end
                endcase
                position_next = pos + POS_W'(1);
                if (in_ch.last && phase_next != PH_DONE)
                    phase_next = PH_ERROR;
            end
            if (phase_next == PH_ERROR)
                patch = 1'b0;
            if (patch && pt < COUNT_MAX)
                patch_total_next = pt + 16'd1;
        end

        patch_valid_next = patch;
        if (!patch)
        begin
            patch_offset_next = '0;
            patch_value_next  = '0;
        end

        priority if (phase_next == PH_DONE)
        begin
            status_next       = STATUS_DONE;
            program_size_next = position_next;
        end
        else if (phase_next == PH_ERROR)
        begin
            status_next       = STATUS_ERROR;
            program_size_next = '0;
        end
        else
        begin
            status_next       = STATUS_RUN;
            program_size_next = '0;
        end
    end

    // chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PTR_LO;
            position_reg     <= '0;
            line_start_reg   <= '0;
            next_pointer_reg <= '0;
            body_length_reg  <= '0;
            target_reg       <= '0;
            source_reg       <= '0;
            patch_total_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            position_reg     <= position_next;
            line_start_reg   <= line_start_next;
            next_pointer_reg <= next_pointer_next;
            body_length_reg  <= body_length_next;
            target_reg       <= target_next;
            source_reg       <= source_next;
            patch_total_reg  <= patch_total_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg       <= status_next;
            patch_valid_reg  <= patch_valid_next;
            patch_offset_reg <= patch_offset_next;
            patch_value_reg  <= patch_value_next;
            program_size_reg <= program_size_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.patch_valid  = patch_valid_reg;
    assign out_ch.patch_offset = patch_offset_reg;
    assign out_ch.patch_value  = patch_value_reg;
    assign out_ch.relink_count = patch_total_reg;
    assign out_ch.program_size = program_size_reg;

    // a patch only comes with a chain still in progress
    a_patch_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && patch_valid_reg) |-> (status_reg == STATUS_RUN))
        else $error("patch beat with a finished or failed chain");

    // size is reported only for a finished chain
    a_size_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && program_size_reg != '0) |-> (status_reg == STATUS_DONE))
        else $error("program size without a finished chain");

    // the rewrite count never falls within one program
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_ch.first) |=> (patch_total_reg >= $past(patch_total_reg)))
        else $error("rewrite count decreased without a restart");

    // a finished or failed chain ignores further bytes
    a_terminal_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_ch.first && (phase_reg == PH_DONE || phase_reg == PH_ERROR))
        |=> ($stable(phase_reg) && $stable(position_reg)))
        else $error("terminal chain state changed without a restart");

endmodule

@@ sim/basic_line_chain_relinker_test.sv @@
// self-checking testbench for the basic line chain relinker: directed and random programs
`timescale 1ns / 1ps

module basic_line_chain_relinker_test;
    import blcr_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int WAIT_MAX     = 19;
    localparam int RANDOM_BYTES = 900;
    localparam int PHASE_BYTES  = 110;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } program_byte_t;

    typedef struct packed {
        status_t     status;
        logic        patch_valid;
        logic [15:0] patch_offset;
        logic [15:0] patch_value;
        logic [15:0] relink_count;
        logic [16:0] program_size;
    } chain_result_t;

    logic clk = 1'b0;
    logic rst_n;

    blcr_in_if  in_ch();
    blcr_out_if out_ch();
    blcr_cfg_if cfg();

    basic_line_chain_relinker i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // register copies
    logic        rel_en   = 1'b0;
    logic [15:0] rel_base = '0;
    logic        chk_en   = 1'b0;
    logic [15:0] chk_base = '0;

    // chain tracking state
    phase_t      chain_phase = PH_PTR_LO;
    logic [16:0] byte_pos    = '0;
    logic [15:0] line_start  = '0;
    logic [15:0] link_ptr    = '0;
    logic [7:0]  body_len    = '0;
    logic [16:0] tgt_run     = '0;
    logic [16:0] src_run     = '0;
    logic [15:0] patch_total = '0;

    program_byte_t byte_queue[$];
    chain_result_t expected_results[$];
    logic [7:0]    program_bytes[$];

    int unsigned bytes_pushed   = 0;
    int unsigned bytes_offered  = 0;
    int unsigned bytes_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned results_paced  = 0;
    int unsigned mismatches     = 0;
    int unsigned patches_seen   = 0;
    int unsigned chains_done    = 0;
    int unsigned chains_failed  = 0;
    int unsigned cycle_count    = 0;
    int unsigned in_wait        = 0;
    int unsigned out_wait       = 0;
    logic        idle_on        = 1'b1;

    function automatic int unsigned draw_wait();
        return idle_on ? $urandom_range(0, WAIT_MAX) : 0;
    endfunction

    function automatic logic [15:0] pick_base();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return 16'h0000;
        if (sel == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic chain_result_t predict_beat(logic [7:0] b, logic f, logic l);
        chain_result_t r;
        phase_t        ph_was;
        logic          patch;
        logic [15:0]   poff;
        logic [15:0]   pval;
        logic [16:0]   span;
        patch = 1'b0;
        poff  = '0;
        pval  = '0;
        if (f)
        begin
            chain_phase = PH_PTR_LO;
            byte_pos    = '0;
            line_start  = '0;
            link_ptr    = '0;
            body_len    = '0;
            tgt_run     = {1'b0, rel_base};
            src_run     = {1'b0, chk_base};
            patch_total = '0;
        end
        ph_was = chain_phase;
        if (chain_phase != PH_DONE && chain_phase != PH_ERROR)
        begin
            if (byte_pos >= MAX_PROGRAM_BYTES)
            begin
                chain_phase = PH_ERROR;
            end
            else
            begin
                case (chain_phase)
                    PH_PTR_LO:
                    begin
                        line_start  = byte_pos[15:0];
                        link_ptr    = {8'h00, b};
                        chain_phase = PH_PTR_HI;
                    end
                    PH_PTR_HI:
                    begin
                        link_ptr[15:8] = b;
                        chain_phase = (link_ptr == 16'h0000) ? PH_DONE : PH_NUM_LO;
                    end
                    PH_NUM_LO:
                        chain_phase = PH_NUM_HI;
                    PH_NUM_HI:
                    begin
                        body_len    = '0;
                        chain_phase = PH_BODY;
                    end
                    default:
                    begin
                        if (b == 8'h00)
                        begin
                            span = byte_pos + 17'd1 - {1'b0, line_start};
                            chain_phase = PH_PTR_LO;
                            if (chk_en)
                            begin
                                src_run = src_run + span;
                                if (src_run != {1'b0, link_ptr})
                                    chain_phase = PH_ERROR;
                            end
                            if (chain_phase != PH_ERROR && rel_en)
                            begin
                                tgt_run = tgt_run + span;
                                if (tgt_run != {1'b0, link_ptr})
                                begin
                                    patch = 1'b1;
                                    poff  = line_start;
                                    pval  = tgt_run[15:0];
                                end
                            end
                        end
                        else
                        begin
                            body_len = body_len + 8'd1;
                            if (body_len >= BODY_LIMIT)
                                chain_phase = PH_ERROR;
                        end
                    end
                endcase
                byte_pos = byte_pos + 17'd1;
                if (l && chain_phase != PH_DONE)
                    chain_phase = PH_ERROR;
            end
            if (chain_phase == PH_ERROR)
                patch = 1'b0;
            if (patch && patch_total < COUNT_MAX)
                patch_total = patch_total + 16'd1;
        end
        if (chain_phase != ph_was && chain_phase == PH_DONE)
            chains_done++;
        if (chain_phase != ph_was && chain_phase == PH_ERROR)
            chains_failed++;
        r.status = (chain_phase == PH_DONE) ? STATUS_DONE :
                   (chain_phase == PH_ERROR) ? STATUS_ERROR : STATUS_RUN;
        r.patch_valid  = patch;
        r.patch_offset = patch ? poff : 16'h0000;
        r.patch_value  = patch ? pval : 16'h0000;
        r.relink_count = patch_total;
        r.program_size = (chain_phase == PH_DONE) ? byte_pos : 17'd0;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [16:0] want, logic [16:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // result checking and byte acceptance
    always @(posedge clk)
    begin : beat_monitor
        chain_result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t result beat with nothing expected: status %0d",
                             $time, out_ch.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", 17'(want.status), 17'(out_ch.status));
                    compare_field("patch_valid", 17'(want.patch_valid),
                                  17'(out_ch.patch_valid));
                    compare_field("patch_offset", 17'(want.patch_offset),
                                  17'(out_ch.patch_offset));
                    compare_field("patch_value", 17'(want.patch_value),
                                  17'(out_ch.patch_value));
                    compare_field("relink_count", 17'(want.relink_count),
                                  17'(out_ch.relink_count));
                    compare_field("program_size", want.program_size, out_ch.program_size);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                bytes_taken++;
                want = predict_beat(in_ch.data_byte, in_ch.first, in_ch.last);
                if (want.patch_valid)
                    patches_seen++;
                expected_results.push_back(want);
            end
        end
    end

    always @(negedge clk)
    begin : byte_driver
        program_byte_t nxt;
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= 8'h00;
            in_ch.first     <= 1'b0;
            in_ch.last      <= 1'b0;
        end
        else if (!in_ch.valid || bytes_taken == bytes_offered)
        begin
            if (in_wait != 0)
            begin
                in_ch.valid <= 1'b0;
                in_wait--;
            end
            else if (byte_queue.size() != 0)
            begin
                nxt = byte_queue.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= nxt.data_byte;
                in_ch.first     <= nxt.first;
                in_ch.last      <= nxt.last;
                bytes_offered++;
                in_wait = draw_wait();
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : result_acceptor
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (results_seen != results_paced)
            begin
                results_paced = results_seen;
                out_wait = draw_wait();
            end
            if (out_wait != 0)
            begin
                out_ch.ready <= 1'b0;
                out_wait--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout: %0d of %0d result beats seen", $time, results_seen,
                     bytes_pushed);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void push_byte(logic [7:0] b, logic f, logic l);
        program_byte_t item;
        item.data_byte = b;
        item.first     = f;
        item.last      = l;
        byte_queue.push_back(item);
        bytes_pushed++;
    endfunction

    function automatic void add_line(logic [15:0] ptr, int unsigned body);
        program_bytes.push_back(ptr[7:0]);
        program_bytes.push_back(ptr[15:8]);
        program_bytes.push_back(8'($urandom));
        program_bytes.push_back(8'($urandom));
        for (int i = 0; i < body; i++)
            program_bytes.push_back(8'($urandom_range(1, 255)));
        program_bytes.push_back(8'h00);
    endfunction

    function automatic void ship_program(int unsigned count, logic mark_last);
        for (int i = 0; i < count; i++)
            push_byte(program_bytes[i], i == 0, mark_last && i == count - 1);
    endfunction

    task automatic settle();
        while (results_seen < bytes_pushed)
            @(negedge clk);
        repeat (3) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            CFG_RELINK_ENABLE: rel_en   = val[0];
            CFG_RELINK_BASE:   rel_base = val;
            CFG_CHECK_ENABLE:  chk_en   = val[0];
            CFG_CHECK_BASE:    chk_base = val;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic re, logic [15:0] rb, logic ce, logic [15:0] cb);
        write_reg(CFG_RELINK_ENABLE, {15'($urandom), re});
        write_reg(CFG_RELINK_BASE, rb);
        write_reg(CFG_CHECK_ENABLE, {15'($urandom), ce});
        write_reg(CFG_CHECK_BASE, cb);
    endtask

    initial
    begin : stimulus
        logic [16:0] gen_src;
        logic [16:0] gen_tgt;
        logic [15:0] ptr;
        logic [15:0] shared_base;
        int unsigned lines;
        int unsigned body;
        int unsigned pick;
        int unsigned cut;
        int unsigned phase_idx;
        int unsigned random_start;
        int unsigned phase_start;

        rst_n           = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = 8'h00;
        cfg.data        = 16'h0000;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // program with no leading first mark, reset bases, then bytes past the end
        push_byte(8'h07, 1'b0, 1'b0);
        push_byte(8'h08, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hA5, 1'b0, 1'b1);
        settle();

        // relink past 16 bits with a passing check
        set_config(1'b1, 16'hFFFF, 1'b1, 16'h0801);
        push_byte(8'h07, 1'b1, 1'b0);
        push_byte(8'h08, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h0C, 1'b0, 1'b0);
        push_byte(8'h08, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        // check mismatch, then an ignored byte
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h09, 1'b0, 1'b0);
        push_byte(8'h0A, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0);
        // data runs out after a pointer, then mid pointer
        push_byte(8'h06, 1'b1, 1'b0);
        push_byte(8'h08, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b1);
        settle();

        random_start = bytes_pushed;
        phase_idx = 0;
        while (bytes_pushed - random_start < RANDOM_BYTES)
        begin
            shared_base = pick_base();
            case (phase_idx)
                0: set_config(1'b1, 16'h0000, 1'b1, 16'h0000);
                1: set_config(1'b1, 16'hFFFF, 1'b0, 16'hFFFF);
                2: set_config(1'b1, shared_base, 1'b1, shared_base);
                3: set_config(1'b0, 16'h0000, 1'b0, 16'h0000);
                default: set_config(1'($urandom), pick_base(), 1'($urandom), pick_base());
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            phase_start = bytes_pushed;
            while (bytes_pushed - phase_start < PHASE_BYTES)
            begin
                program_bytes.delete();
                gen_src = {1'b0, chk_base};
                gen_tgt = {1'b0, rel_base};
                if ($urandom_range(0, 19) == 0)
                begin
                    repeat ($urandom_range(1, 12)) program_bytes.push_back(8'($urandom));
                end
                else
                begin
                    lines = $urandom_range(1, 4);
                    for (int i = 0; i < lines; i++)
                    begin
                        pick = $urandom_range(0, 199);
                        body = (pick < 3) ? $urandom_range(250, 258) :
                               (pick < 11) ? $urandom_range(20, 80) : $urandom_range(0, 6);
                        gen_src = gen_src + 17'(body + 5);
                        gen_tgt = gen_tgt + 17'(body + 5);
                        pick = $urandom_range(0, 9);
                        ptr = (pick < 7) ? gen_src[15:0] :
                              (pick < 9) ? gen_tgt[15:0] : 16'($urandom_range(1, 65535));
                        add_line(ptr, body);
                    end
                    program_bytes.push_back(8'h00);
                    program_bytes.push_back(8'h00);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    cut = $urandom_range(1, program_bytes.size());
                    ship_program(cut, 1'b1);
                end
                else
                begin
                    ship_program(program_bytes.size(), 1'($urandom));
                end
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'($urandom));
            end
            settle();
            phase_idx++;
        end

        $display("checked %0d result beats for %0d program bytes over %0d register settings",
                 results_seen, bytes_taken, phase_idx + 2);
        $display("%0d patches, %0d chains ended cleanly, %0d chains ended in error",
                 patches_seen, chains_done, chains_failed);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/blcr_pkg.sv
rtl/core/blcr_in_if.sv
rtl/core/blcr_out_if.sv
rtl/core/blcr_cfg_if.sv
rtl/core/basic_line_chain_relinker.sv
sim/basic_line_chain_relinker_test.sv
